// ----- rtl/rbf_pkg.sv -----
// rbf_pkg: shared types and constants for the byte ring fifo with peek
// operation and status codes, field widths and the per-item result metadata
// no dependencies
`timescale 1ns / 1ps

package rbf_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned COUNT_W = 8;

   typedef enum logic [1:0] {
      OP_PUT     = 2'd0,
      OP_GET     = 2'd1,
      OP_PEEK    = 2'd2,
      OP_DISCARD = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_UNDER = 2'd2
   } status_type;

   typedef struct packed {
      logic                 read_hit;
      status_type           status;
      logic [COUNT_W-1:0]   bytes_used;
      logic [COUNT_W-1:0]   bytes_free;
   } meta_type;

endpackage

// ----- rtl/rbf_if.sv -----
// rbf_req_if and rbf_rsp_if: valid/ready channels for operations and results
// depends on rbf_pkg for field widths
`timescale 1ns / 1ps

interface rbf_req_if import rbf_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [1:0]        operation;
   logic [BYTE_W-1:0] data_in;
   logic [BYTE_W-1:0] offset;
   logic [BYTE_W-1:0] count;

   modport source (output valid, output operation, output data_in, output offset,
                   output count, input ready);
   modport sink   (input valid, input operation, input data_in, input offset,
                   input count, output ready);
endinterface

interface rbf_rsp_if import rbf_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [BYTE_W-1:0]  data_out;
   logic [1:0]         status;
   logic [COUNT_W-1:0] bytes_used;
   logic [COUNT_W-1:0] bytes_free;

   modport source (output valid, output data_out, output status, output bytes_used,
                   output bytes_free, input ready);
   modport sink   (input valid, input data_out, input status, input bytes_used,
                   input bytes_free, output ready);
endinterface

// ----- rtl/rbf_mem.sv -----
// rbf_mem: byte store, one write port and one read port, registered read data
// depends on rbf_pkg for the byte width
`timescale 1ns / 1ps

module rbf_mem import rbf_pkg::*; #(
   parameter int unsigned DEPTH = 256,
   parameter int unsigned AW    = 8
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [BYTE_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output logic [BYTE_W-1:0] rd_data
);

   logic [BYTE_W-1:0] mem [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/rbf_ctrl.sv -----
// rbf_ctrl: read/write pointers and fill count, operation decode and status
// depends on rbf_pkg; drives the ports of rbf_mem
`timescale 1ns / 1ps

module rbf_ctrl import rbf_pkg::*; #(
   parameter int unsigned DEPTH = 256,
   parameter int unsigned AW    = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  op_type            operation,
   input  logic [BYTE_W-1:0] data_in,
   input  logic [BYTE_W-1:0] offset,
   input  logic [BYTE_W-1:0] count,
   output logic              wr_en,
   output logic [AW-1:0]     wr_addr,
   output logic [BYTE_W-1:0] wr_data,
   output logic              rd_en,
   output logic [AW-1:0]     rd_addr,
   output meta_type          meta
);

   localparam int unsigned SW = ((AW > BYTE_W) ? AW : BYTE_W) + 1;

   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] used_ff, used_in;

   logic [SW-1:0] used_ext;
   logic [SW-1:0] step_ext;
   logic [SW-1:0] sum_raw;
   logic [SW-1:0] sum_wrap;
   logic [SW-1:0] free_ext;
   logic          full;
   logic          empty;
   status_type    status;
   logic          read_hit;

   assign used_ext = SW'(used_ff);
   assign full     = (used_ff == AW'(DEPTH - 1));
   assign empty    = (used_ff == '0);

   // head plus distance, wrapped once around the ring
   always_comb begin
      unique case (operation)
         OP_PEEK:    step_ext = SW'(offset);
         OP_DISCARD: step_ext = SW'(count);
         default:    step_ext = '0;
      endcase
      sum_raw = SW'(rd_ptr_ff) + step_ext;
      if (sum_raw >= SW'(DEPTH)) begin
         sum_wrap = sum_raw - SW'(DEPTH);
      end else begin
         sum_wrap = sum_raw;
      end
   end

   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      used_in   = used_ff;
      status    = ST_OK;
      read_hit  = 1'b0;
      wr_en     = 1'b0;
      rd_en     = 1'b0;
      unique case (operation)
         OP_PUT: begin
            if (full) begin
               status = ST_FULL;
            end else begin
               wr_en     = accept;
               wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
               used_in   = used_ff + AW'(1);
            end
         end
         OP_GET: begin
            if (empty) begin
               status = ST_UNDER;
            end else begin
               read_hit  = 1'b1;
               rd_en     = accept;
               rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
               used_in   = used_ff - AW'(1);
            end
         end
         OP_PEEK: begin
            if (SW'(offset) >= used_ext) begin
               status = ST_UNDER;
            end else begin
               read_hit = 1'b1;
               rd_en    = accept;
            end
         end
         OP_DISCARD: begin
            if (SW'(count) > used_ext) begin
               status = ST_UNDER;
            end else begin
               rd_ptr_in = sum_wrap[AW-1:0];
               used_in   = AW'(used_ext - SW'(count));
            end
         end
         default: begin
            status = ST_OK;
         end
      endcase
   end

   assign wr_addr = wr_ptr_ff;
   assign wr_data = data_in;
   assign rd_addr = sum_wrap[AW-1:0];

   // counts after this operation, saturated to the field width
   assign free_ext = SW'(DEPTH - 1) - SW'(used_in);

   always_comb begin
      meta.read_hit = read_hit;
      meta.status   = status;
      if (SW'(used_in) > SW'({COUNT_W{1'b1}})) begin
         meta.bytes_used = '1;
      end else begin
         meta.bytes_used = COUNT_W'(used_in);
      end
      if (free_ext > SW'({COUNT_W{1'b1}})) begin
         meta.bytes_free = '1;
      end else begin
         meta.bytes_free = COUNT_W'(free_ext);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         used_ff   <= '0;
      end else if (accept) begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         used_ff   <= used_in;
      end
   end

endmodule

// ----- rtl/byte_ring_fifo_with_peek.sv -----
// byte_ring_fifo_with_peek: top level, memory stage and result register
// depends on rbf_pkg, rbf_if, rbf_mem and rbf_ctrl
`timescale 1ns / 1ps

// Byte ring fifo holding up to DEPTH-1 bytes, one slot always left empty.
// Each request is one operation (put, get, peek at an offset from the head,
// discard a count) and yields exactly one response with the byte read, a
// status and the used/free counts after the operation (saturated at 255).
// One operation is accepted per clock cycle when the response side keeps up;
// its result passes from the memory stage, where the byte store's registered
// read data arrives, into the response register, which holds it until it
// transfers. A stalled response holds the request side only once both the
// memory stage and the response register are full. Pointers and fill count
// update at the request transfer, so later operations always see earlier
// ones. No clearing pass follows reset.

module byte_ring_fifo_with_peek import rbf_pkg::*; #(
   parameter int unsigned DEPTH = 256
) (
   input  logic      clock,
   input  logic      reset,
   rbf_req_if.sink   req_if,
   rbf_rsp_if.source rsp_if
);

   localparam int unsigned AW = $clog2(DEPTH);

   logic              accept;
   logic              rsp_take;
   logic              out_free;
   logic              stage_move;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [BYTE_W-1:0] wr_data;
   logic              rd_en;
   logic [AW-1:0]     rd_addr;
   logic [BYTE_W-1:0] rd_data;
   meta_type          meta;

   logic              stage_valid_ff, stage_valid_in;
   meta_type          stage_meta_ff;
   logic              out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0] out_data_ff;
   meta_type          out_meta_ff;

   assign rsp_take     = out_valid_ff && rsp_if.ready;
   assign out_free     = !out_valid_ff || rsp_if.ready;
   assign stage_move   = stage_valid_ff && out_free;
   assign req_if.ready = !stage_valid_ff || out_free;
   assign accept       = req_if.valid && req_if.ready;

   rbf_ctrl #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .operation (op_type'(req_if.operation)),
      .data_in   (req_if.data_in),
      .offset    (req_if.offset),
      .count     (req_if.count),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .meta      (meta)
   );

   rbf_mem #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      priority if (accept) begin
         stage_valid_in = 1'b1;
      end else if (stage_move) begin
         stage_valid_in = 1'b0;
      end else begin
         stage_valid_in = stage_valid_ff;
      end
   end

   always_comb begin
      priority if (stage_move) begin
         out_valid_in = 1'b1;
      end else if (rsp_take) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_meta_ff <= meta;
      end
      if (stage_move) begin
         out_meta_ff <= stage_meta_ff;
         out_data_ff <= stage_meta_ff.read_hit ? rd_data : '0;
      end
   end

   assign rsp_if.valid      = out_valid_ff;
   assign rsp_if.data_out   = out_data_ff;
   assign rsp_if.status     = out_meta_ff.status;
   assign rsp_if.bytes_used = out_meta_ff.bytes_used;
   assign rsp_if.bytes_free = out_meta_ff.bytes_free;

endmodule
